FILE: hdl/ascf_pkg.sv
// shared types and constants for the ascii can frame line parser
`timescale 1ns / 1ps

package ascf_pkg;

   localparam int LINE_CAPACITY = 64;
   localparam int MAX_PAYLOAD   = 8;
   localparam int ID_W          = 32;
   localparam int DLC_W         = 4;

   localparam logic [7:0] CH_NUL   = 8'h00;
   localparam logic [7:0] CH_TAB   = 8'h09;
   localparam logic [7:0] CH_LF    = 8'h0A;
   localparam logic [7:0] CH_VT    = 8'h0B;
   localparam logic [7:0] CH_FF    = 8'h0C;
   localparam logic [7:0] CH_CR    = 8'h0D;
   localparam logic [7:0] CH_SPACE = 8'h20;
   localparam logic [7:0] CH_PLUS  = 8'h2B;
   localparam logic [7:0] CH_MINUS = 8'h2D;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_EIGHT = 8'h38;
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_C  = 8'h43;
   localparam logic [7:0] CH_UP_N  = 8'h4E;
   localparam logic [7:0] CH_UP_X  = 8'h58;
   localparam logic [7:0] CH_LO_X  = 8'h78;

   typedef enum logic [3:0] {
      PH_PFX0      = 4'd0,
      PH_PFX1      = 4'd1,
      PH_PFX2      = 4'd2,
      PH_PFX3      = 4'd3,
      PH_ID_START  = 4'd4,
      PH_ID_SIGNED = 4'd5,
      PH_ID_ZERO   = 4'd6,
      PH_ID_XPFX   = 4'd7,
      PH_ID_DIGITS = 4'd8,
      PH_DLC       = 4'd9,
      PH_DLC_COLON = 4'd10,
      PH_DATA_HI   = 4'd11,
      PH_DATA_LO   = 4'd12,
      PH_DONE      = 4'd13,
      PH_DEAD      = 4'd14
   } phase_type;

   typedef struct packed {
      logic                             status;
      logic [ID_W-1:0]                  frame_id;
      logic [DLC_W-1:0]                 length_code;
      logic [MAX_PAYLOAD-1:0][7:0]      data;
   } rsp_type;

   typedef struct packed {
      logic    push;
      rsp_type rsp;
   } push_type;

endpackage

FILE: hdl/ascf_parser_core.sv
// per-character line parser state and result generation
`timescale 1ns / 1ps

module ascf_parser_core #(
   parameter int LINE_CAPACITY = ascf_pkg::LINE_CAPACITY
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               char_fire,
   input  logic [7:0]         char_in,
   output ascf_pkg::push_type push_out
);

   localparam int LEN_W = $clog2(LINE_CAPACITY);
   localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(LINE_CAPACITY - 1);
   localparam int CNT_W = $clog2(ascf_pkg::MAX_PAYLOAD + 1);
   localparam int IDX_W = $clog2(ascf_pkg::MAX_PAYLOAD);

   logic [LEN_W-1:0]                   len_ff, len_in;
   ascf_pkg::phase_type                phase_ff, phase_in;
   logic [ascf_pkg::ID_W-1:0]          acc_ff, acc_in;
   logic                               ovf_ff, ovf_in;
   logic                               neg_ff, neg_in;
   logic [ascf_pkg::DLC_W-1:0]         dlc_ff, dlc_in;
   logic [ascf_pkg::MAX_PAYLOAD-1:0][7:0] store_ff, store_in;
   logic [CNT_W-1:0]                   cnt_ff, cnt_in;
   logic [4:0]                         pend_ff, pend_in;

   logic       hex_ok;
   logic [3:0] nib;
   logic       do_add;
   logic       accepts;

   // hex digit decode
   always_comb begin
      hex_ok = 1'b1;
      nib    = 4'd0;
      if (char_in inside {[8'h30:8'h39]}) begin
         nib = 4'(char_in - 8'h30);
      end else if (char_in inside {[8'h41:8'h46]}) begin
         nib = 4'(char_in - 8'h37);
      end else if (char_in inside {[8'h61:8'h66]}) begin
         nib = 4'(char_in - 8'h57);
      end else begin
         hex_ok = 1'b0;
      end
   end

   assign accepts = (phase_ff == ascf_pkg::PH_DATA_HI) || (phase_ff == ascf_pkg::PH_DATA_LO) ||
                    (phase_ff == ascf_pkg::PH_DONE);

   always_comb begin
      len_in   = len_ff;
      phase_in = phase_ff;
      acc_in   = acc_ff;
      ovf_in   = ovf_ff;
      neg_in   = neg_ff;
      dlc_in   = dlc_ff;
      store_in = store_ff;
      cnt_in   = cnt_ff;
      pend_in  = pend_ff;
      do_add   = 1'b0;
      push_out = '0;

      if (char_fire) begin
         if ((char_in == ascf_pkg::CH_LF) || (char_in == ascf_pkg::CH_CR)) begin
            if (len_ff != '0) begin
               push_out.push = 1'b1;
               if (accepts) begin
                  push_out.rsp.status = 1'b0;
                  if (ovf_ff) begin
                     push_out.rsp.frame_id = '1;
                  end else if (neg_ff) begin
                     push_out.rsp.frame_id = '0 - acc_ff;
                  end else begin
                     push_out.rsp.frame_id = acc_ff;
                  end
                  push_out.rsp.length_code = dlc_ff;
                  push_out.rsp.data        = store_ff;
               end else begin
                  push_out.rsp.status = 1'b1;
               end
               len_in   = '0;
               phase_in = ascf_pkg::PH_PFX0;
               acc_in   = '0;
               ovf_in   = 1'b0;
               neg_in   = 1'b0;
               dlc_in   = '0;
               store_in = '0;
               cnt_in   = '0;
               pend_in  = '0;
            end
         end else if (len_ff != LEN_MAX) begin
            len_in = len_ff + 1'b1;
            if (char_in == ascf_pkg::CH_NUL) begin
               phase_in = accepts ? ascf_pkg::PH_DONE : ascf_pkg::PH_DEAD;
            end else begin
               case (phase_ff)
                  ascf_pkg::PH_PFX0: begin
                     phase_in = (char_in == ascf_pkg::CH_UP_C) ? ascf_pkg::PH_PFX1
                                                               : ascf_pkg::PH_DEAD;
                  end
                  ascf_pkg::PH_PFX1: begin
                     phase_in = (char_in == ascf_pkg::CH_UP_A) ? ascf_pkg::PH_PFX2
                                                               : ascf_pkg::PH_DEAD;
                  end
                  ascf_pkg::PH_PFX2: begin
                     phase_in = (char_in == ascf_pkg::CH_UP_N) ? ascf_pkg::PH_PFX3
                                                               : ascf_pkg::PH_DEAD;
                  end
                  ascf_pkg::PH_PFX3: begin
                     phase_in = (char_in == ascf_pkg::CH_COLON) ? ascf_pkg::PH_ID_START
                                                                : ascf_pkg::PH_DEAD;
                  end
                  ascf_pkg::PH_ID_START, ascf_pkg::PH_ID_SIGNED: begin
                     if ((phase_ff == ascf_pkg::PH_ID_START) &&
                         ((char_in == ascf_pkg::CH_SPACE) || (char_in == ascf_pkg::CH_TAB) ||
                          (char_in == ascf_pkg::CH_VT) || (char_in == ascf_pkg::CH_FF))) begin
                        phase_in = phase_ff;
                     end else if ((phase_ff == ascf_pkg::PH_ID_START) &&
                                  ((char_in == ascf_pkg::CH_PLUS) ||
                                   (char_in == ascf_pkg::CH_MINUS))) begin
                        neg_in   = (char_in == ascf_pkg::CH_MINUS);
                        phase_in = ascf_pkg::PH_ID_SIGNED;
                     end else if (char_in == ascf_pkg::CH_ZERO) begin
                        phase_in = ascf_pkg::PH_ID_ZERO;
                     end else if (hex_ok) begin
                        do_add   = 1'b1;
                        phase_in = ascf_pkg::PH_ID_DIGITS;
                     end else begin
                        phase_in = ascf_pkg::PH_DEAD;
                     end
                  end
                  ascf_pkg::PH_ID_ZERO: begin
                     if ((char_in == ascf_pkg::CH_LO_X) || (char_in == ascf_pkg::CH_UP_X)) begin
                        phase_in = ascf_pkg::PH_ID_XPFX;
                     end else if (hex_ok) begin
                        do_add   = 1'b1;
                        phase_in = ascf_pkg::PH_ID_DIGITS;
                     end else begin
                        phase_in = (char_in == ascf_pkg::CH_COLON) ? ascf_pkg::PH_DLC
                                                                   : ascf_pkg::PH_DEAD;
                     end
                  end
                  ascf_pkg::PH_ID_XPFX: begin
                     if (hex_ok) begin
                        do_add   = 1'b1;
                        phase_in = ascf_pkg::PH_ID_DIGITS;
                     end else begin
                        phase_in = ascf_pkg::PH_DEAD;
                     end
                  end
                  ascf_pkg::PH_ID_DIGITS: begin
                     if (hex_ok) begin
                        do_add = 1'b1;
                     end else begin
                        phase_in = (char_in == ascf_pkg::CH_COLON) ? ascf_pkg::PH_DLC
                                                                   : ascf_pkg::PH_DEAD;
                     end
                  end
                  ascf_pkg::PH_DLC: begin
                     if (char_in inside {[ascf_pkg::CH_ZERO:ascf_pkg::CH_EIGHT]}) begin
                        dlc_in   = 4'(char_in - ascf_pkg::CH_ZERO);
                        phase_in = ascf_pkg::PH_DLC_COLON;
                     end else begin
                        phase_in = ascf_pkg::PH_DEAD;
                     end
                  end
                  ascf_pkg::PH_DLC_COLON: begin
                     phase_in = (char_in == ascf_pkg::CH_COLON) ? ascf_pkg::PH_DATA_HI
                                                                : ascf_pkg::PH_DEAD;
                  end
                  ascf_pkg::PH_DATA_HI: begin
                     pend_in  = hex_ok ? {1'b0, nib} : 5'b10000;
                     phase_in = ascf_pkg::PH_DATA_LO;
                  end
                  ascf_pkg::PH_DATA_LO: begin
                     if (pend_ff[4] || !hex_ok) begin
                        phase_in = ascf_pkg::PH_DEAD;
                     end else begin
                        store_in[cnt_ff[IDX_W-1:0]] = {pend_ff[3:0], nib};
                        cnt_in  = cnt_ff + 1'b1;
                        pend_in = '0;
                        phase_in = (cnt_in >= CNT_W'(ascf_pkg::MAX_PAYLOAD))
                                   ? ascf_pkg::PH_DONE : ascf_pkg::PH_DATA_HI;
                     end
                  end
                  default: begin
                     phase_in = phase_ff;
                  end
               endcase
            end

            // saturating id accumulate
            if (do_add) begin
               if (acc_ff[ascf_pkg::ID_W-1 -: 4] != 4'd0) begin
                  ovf_in = 1'b1;
               end else begin
                  acc_in = {acc_ff[ascf_pkg::ID_W-5:0], nib};
               end
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         len_ff   <= '0;
         phase_ff <= ascf_pkg::PH_PFX0;
         acc_ff   <= '0;
         ovf_ff   <= 1'b0;
         neg_ff   <= 1'b0;
         dlc_ff   <= '0;
         store_ff <= '0;
         cnt_ff   <= '0;
         pend_ff  <= '0;
      end else begin
         len_ff   <= len_in;
         phase_ff <= phase_in;
         acc_ff   <= acc_in;
         ovf_ff   <= ovf_in;
         neg_ff   <= neg_in;
         dlc_ff   <= dlc_in;
         store_ff <= store_in;
         cnt_ff   <= cnt_in;
         pend_ff  <= pend_in;
      end
   end

endmodule

FILE: hdl/ascf_rsp_skid.sv
// result output register with skid stage
`timescale 1ns / 1ps

module ascf_rsp_skid (
   input  logic               clock,
   input  logic               reset,
   input  ascf_pkg::push_type push_in,
   output logic               space_ok,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output ascf_pkg::rsp_type  rsp_data
);

   logic              out_valid_ff, out_valid_in;
   logic              skid_valid_ff, skid_valid_in;
   ascf_pkg::rsp_type out_ff, out_in;
   ascf_pkg::rsp_type skid_ff, skid_in;
   logic              pop;

   assign pop       = out_valid_ff && rsp_ready;
   assign space_ok  = !skid_valid_ff;
   assign rsp_valid = out_valid_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      out_valid_in  = out_valid_ff;
      skid_valid_in = skid_valid_ff;
      out_in        = out_ff;
      skid_in       = skid_ff;
      if (pop && skid_valid_ff) begin
         out_in        = skid_ff;
         skid_valid_in = 1'b0;
      end else if (push_in.push) begin
         if (!out_valid_ff || pop) begin
            out_in       = push_in.rsp;
            out_valid_in = 1'b1;
         end else begin
            skid_in       = push_in.rsp;
            skid_valid_in = 1'b1;
         end
      end else if (pop) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff  <= 1'b0;
         skid_valid_ff <= 1'b0;
      end else begin
         out_valid_ff  <= out_valid_in;
         skid_valid_ff <= skid_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff  <= out_in;
      skid_ff <= skid_in;
   end

endmodule

FILE: hdl/ascii_can_frame_line_parser.sv
// top level of the ascii can frame line parser
// a line end's result is registered into the output register, or into the skid stage
// throughput: one character per cycle while req_ready is high
// req_ready drops only while both the output register and the skid stage hold results
// reset: synchronous, clears the parser state to prefix match and empties the output stage
`timescale 1ns / 1ps

module ascii_can_frame_line_parser #(
   parameter int LINE_CAPACITY = ascf_pkg::LINE_CAPACITY
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_ready,
   input  logic [7:0]  req_char_in,
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic        rsp_status,
   output logic [31:0] rsp_frame_id,
   output logic [3:0]  rsp_length_code,
   output logic [7:0]  rsp_data_byte_0,
   output logic [7:0]  rsp_data_byte_1,
   output logic [7:0]  rsp_data_byte_2,
   output logic [7:0]  rsp_data_byte_3,
   output logic [7:0]  rsp_data_byte_4,
   output logic [7:0]  rsp_data_byte_5,
   output logic [7:0]  rsp_data_byte_6,
   output logic [7:0]  rsp_data_byte_7
);

   ascf_pkg::push_type push_bus;
   ascf_pkg::rsp_type  rsp_bus;
   logic               space_ok;
   logic               char_fire;

   assign req_ready = space_ok;
   assign char_fire = req_valid && space_ok;

   ascf_parser_core #(
      .LINE_CAPACITY(LINE_CAPACITY)
   ) u_core (
      .clock    (clock),
      .reset    (reset),
      .char_fire(char_fire),
      .char_in  (req_char_in),
      .push_out (push_bus)
   );

   ascf_rsp_skid u_skid (
      .clock    (clock),
      .reset    (reset),
      .push_in  (push_bus),
      .space_ok (space_ok),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_data (rsp_bus)
   );

   assign rsp_status      = rsp_bus.status;
   assign rsp_frame_id    = rsp_bus.frame_id;
   assign rsp_length_code = rsp_bus.length_code;
   assign rsp_data_byte_0 = rsp_bus.data[0];
   assign rsp_data_byte_1 = rsp_bus.data[1];
   assign rsp_data_byte_2 = rsp_bus.data[2];
   assign rsp_data_byte_3 = rsp_bus.data[3];
   assign rsp_data_byte_4 = rsp_bus.data[4];
   assign rsp_data_byte_5 = rsp_bus.data[5];
   assign rsp_data_byte_6 = rsp_bus.data[6];
   assign rsp_data_byte_7 = rsp_bus.data[7];

   // skid stage only fills behind a waiting result
   a_skid_behind_out: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> rsp_valid)
      else $error("skid stage full with empty output register");

   // a rejected line carries all-zero fields
   a_reject_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_status) |-> ((rsp_frame_id == 32'd0) && (rsp_length_code == 4'd0) &&
                                     (rsp_data_byte_0 == 8'd0) && (rsp_data_byte_7 == 8'd0)))
      else $error("rejected line with nonzero fields");

   // length code is a single digit up to eight
   a_dlc_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_length_code <= 4'd8))
      else $error("length code out of range");

endmodule

FILE: verif/ascf_frame_checker.sv
// frame checker: predicts parser results from accepted characters and compares each response
`timescale 1ns / 1ps

module ascf_frame_checker
   import ascf_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   input  logic        req_ready,
   input  logic [7:0]  req_char_in,
   input  logic        rsp_valid,
   input  logic        rsp_ready,
   input  logic        rsp_status,
   input  logic [31:0] rsp_frame_id,
   input  logic [3:0]  rsp_length_code,
   input  logic [7:0]  rsp_data_byte_0,
   input  logic [7:0]  rsp_data_byte_1,
   input  logic [7:0]  rsp_data_byte_2,
   input  logic [7:0]  rsp_data_byte_3,
   input  logic [7:0]  rsp_data_byte_4,
   input  logic [7:0]  rsp_data_byte_5,
   input  logic [7:0]  rsp_data_byte_6,
   input  logic [7:0]  rsp_data_byte_7,
   output int          fail_count,
   output int          pending,
   output int          accepted_frames,
   output int          rejected_lines
);

   localparam int PRINT_CAP = 40;

   // line parser copy
   int              line_chars;
   phase_type       phase;
   logic [31:0]     id_acc;
   logic            id_ovf;
   logic            id_neg;
   logic [3:0]      dlc_val;
   logic [7:0]      pay_bytes [MAX_PAYLOAD];
   int              pay_cnt;
   logic [4:0]      pend_nib;

   rsp_type         frame_q [$];
   longint unsigned cycle_no;

   function automatic logic [4:0] hex_nibble(logic [7:0] c);
      if (c >= "0" && c <= "9") return {1'b0, c[3:0]};
      if (c >= "A" && c <= "F") return 5'(c - "A" + 8'd10);
      if (c >= "a" && c <= "f") return 5'(c - "a" + 8'd10);
      return 5'h10;
   endfunction

   function automatic bit line_is_good(phase_type ph);
      return ph == PH_DATA_HI || ph == PH_DATA_LO || ph == PH_DONE;
   endfunction

   task automatic clear_line_state();
      line_chars = 0;
      phase      = PH_PFX0;
      id_acc     = '0;
      id_ovf     = 1'b0;
      id_neg     = 1'b0;
      dlc_val    = '0;
      pay_cnt    = 0;
      pend_nib   = '0;
      for (int i = 0; i < MAX_PAYLOAD; i++) pay_bytes[i] = '0;
   endtask

   // strtoul style accumulate, sticky saturation
   task automatic id_shift_in(logic [3:0] d);
      if (id_acc[31:28] != 4'd0) id_ovf = 1'b1;
      else id_acc = {id_acc[27:0], d};
   endtask

   task automatic advance_phase(logic [7:0] c);
      logic [4:0] nib;
      bit         digit_like;
      nib        = hex_nibble(c);
      digit_like = 1'b0;
      if (c == CH_NUL) begin
         phase = line_is_good(phase) ? PH_DONE : PH_DEAD;
      end else begin
         case (phase)
            PH_PFX0: phase = (c == CH_UP_C) ? PH_PFX1 : PH_DEAD;
            PH_PFX1: phase = (c == CH_UP_A) ? PH_PFX2 : PH_DEAD;
            PH_PFX2: phase = (c == CH_UP_N) ? PH_PFX3 : PH_DEAD;
            PH_PFX3: phase = (c == CH_COLON) ? PH_ID_START : PH_DEAD;
            PH_ID_START: begin
               if (c == CH_SPACE || c == CH_TAB || c == CH_VT || c == CH_FF) begin
               end else if (c == CH_PLUS || c == CH_MINUS) begin
                  id_neg = (c == CH_MINUS);
                  phase  = PH_ID_SIGNED;
               end else begin
                  digit_like = 1'b1;
               end
            end
            PH_ID_SIGNED: digit_like = 1'b1;
            PH_ID_ZERO: begin
               if (c == CH_LO_X || c == CH_UP_X) phase = PH_ID_XPFX;
               else if (!nib[4]) begin
                  id_shift_in(nib[3:0]);
                  phase = PH_ID_DIGITS;
               end else phase = (c == CH_COLON) ? PH_DLC : PH_DEAD;
            end
            PH_ID_XPFX: begin
               if (!nib[4]) begin
                  id_shift_in(nib[3:0]);
                  phase = PH_ID_DIGITS;
               end else phase = PH_DEAD;
            end
            PH_ID_DIGITS: begin
               if (!nib[4]) id_shift_in(nib[3:0]);
               else phase = (c == CH_COLON) ? PH_DLC : PH_DEAD;
            end
            PH_DLC: begin
               if (c >= CH_ZERO && c <= CH_EIGHT) begin
                  dlc_val = c[3:0];
                  phase   = PH_DLC_COLON;
               end else phase = PH_DEAD;
            end
            PH_DLC_COLON: phase = (c == CH_COLON) ? PH_DATA_HI : PH_DEAD;
            PH_DATA_HI: begin
               pend_nib = nib;
               phase    = PH_DATA_LO;
            end
            PH_DATA_LO: begin
               if (pend_nib[4] || nib[4]) begin
                  phase = PH_DEAD;
               end else begin
                  if (pay_cnt < MAX_PAYLOAD) pay_bytes[pay_cnt] = {pend_nib[3:0], nib[3:0]};
                  pay_cnt++;
                  pend_nib = '0;
                  phase    = (pay_cnt >= MAX_PAYLOAD) ? PH_DONE : PH_DATA_HI;
               end
            end
            default: begin
            end
         endcase
         if (digit_like) begin
            if (c == CH_ZERO) phase = PH_ID_ZERO;
            else if (!nib[4]) begin
               id_shift_in(nib[3:0]);
               phase = PH_ID_DIGITS;
            end else phase = PH_DEAD;
         end
      end
   endtask

   task automatic feed_char(logic [7:0] c);
      rsp_type frame;
      if (c == CH_LF || c == CH_CR) begin
         if (line_chars != 0) begin
            frame = '0;
            if (line_is_good(phase)) begin
               frame.status      = 1'b0;
               frame.frame_id    = id_ovf ? 32'hFFFF_FFFF : (id_neg ? -id_acc : id_acc);
               frame.length_code = dlc_val;
               for (int i = 0; i < MAX_PAYLOAD; i++)
                  frame.data[i] = (i < pay_cnt) ? pay_bytes[i] : 8'h00;
               accepted_frames++;
            end else begin
               frame.status = 1'b1;
               rejected_lines++;
            end
            frame_q.push_back(frame);
            clear_line_state();
         end
      end else if (line_chars < LINE_CAPACITY - 1) begin
         line_chars++;
         advance_phase(c);
      end
   endtask

   task automatic report_mismatch(string what, logic [31:0] got_v, logic [31:0] want_v);
      fail_count++;
      if (fail_count <= PRINT_CAP)
         $display("mismatch at cycle %0d: %s got %h want %h", cycle_no, what, got_v, want_v);
   endtask

   task automatic check_frame();
      rsp_type    want;
      logic [7:0] got_byte [MAX_PAYLOAD];
      got_byte[0] = rsp_data_byte_0;
      got_byte[1] = rsp_data_byte_1;
      got_byte[2] = rsp_data_byte_2;
      got_byte[3] = rsp_data_byte_3;
      got_byte[4] = rsp_data_byte_4;
      got_byte[5] = rsp_data_byte_5;
      got_byte[6] = rsp_data_byte_6;
      got_byte[7] = rsp_data_byte_7;
      if (frame_q.size() == 0) begin
         report_mismatch("response with no frame pending", 32'(rsp_status), 32'd0);
      end else begin
         want = frame_q.pop_front();
         if (rsp_status !== want.status)
            report_mismatch("status", 32'(rsp_status), 32'(want.status));
         if (rsp_frame_id !== want.frame_id)
            report_mismatch("frame_id", rsp_frame_id, want.frame_id);
         if (rsp_length_code !== want.length_code)
            report_mismatch("length_code", 32'(rsp_length_code), 32'(want.length_code));
         for (int i = 0; i < MAX_PAYLOAD; i++)
            if (got_byte[i] !== want.data[i])
               report_mismatch($sformatf("data_byte_%0d", i), 32'(got_byte[i]),
                               32'(want.data[i]));
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         clear_line_state();
         frame_q.delete();
         fail_count      = 0;
         accepted_frames = 0;
         rejected_lines  = 0;
         cycle_no        = 0;
      end else begin
         cycle_no++;
         if (req_valid && req_ready) feed_char(req_char_in);
         if (rsp_valid && rsp_ready) check_frame();
      end
      pending <= frame_q.size();
   end

endmodule

FILE: verif/ascii_can_frame_line_parser_tb.sv
// testbench top: character stimulus, response backpressure and verdict for the line parser
`timescale 1ns / 1ps

module ascii_can_frame_line_parser_tb;
   import ascf_pkg::*;

   localparam int CYCLE_LIMIT = 400000;
   localparam int PHASE_CHARS = 120;

   logic        clock = 1'b0;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [7:0]  req_char_in;
   logic        rsp_valid;
   logic        rsp_ready;
   logic        rsp_status;
   logic [31:0] rsp_frame_id;
   logic [3:0]  rsp_length_code;
   logic [7:0]  rsp_data_byte_0;
   logic [7:0]  rsp_data_byte_1;
   logic [7:0]  rsp_data_byte_2;
   logic [7:0]  rsp_data_byte_3;
   logic [7:0]  rsp_data_byte_4;
   logic [7:0]  rsp_data_byte_5;
   logic [7:0]  rsp_data_byte_6;
   logic [7:0]  rsp_data_byte_7;

   int          fail_count;
   int          pending;
   int          accepted_frames;
   int          rejected_lines;

   int          send_idle;
   int          recv_idle;
   logic        rsp_hold;
   int          cycle_count;
   int          chars_sent;
   int          lines_sent;
   logic [7:0]  line_q [$];

   always begin
      #10 clock = 1'b1;
      #10 clock = 1'b0;
   end

   ascii_can_frame_line_parser DUT (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_in     (req_char_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_frame_id    (rsp_frame_id),
      .rsp_length_code (rsp_length_code),
      .rsp_data_byte_0 (rsp_data_byte_0),
      .rsp_data_byte_1 (rsp_data_byte_1),
      .rsp_data_byte_2 (rsp_data_byte_2),
      .rsp_data_byte_3 (rsp_data_byte_3),
      .rsp_data_byte_4 (rsp_data_byte_4),
      .rsp_data_byte_5 (rsp_data_byte_5),
      .rsp_data_byte_6 (rsp_data_byte_6),
      .rsp_data_byte_7 (rsp_data_byte_7)
   );

   ascf_frame_checker u_checker (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_ready       (req_ready),
      .req_char_in     (req_char_in),
      .rsp_valid       (rsp_valid),
      .rsp_ready       (rsp_ready),
      .rsp_status      (rsp_status),
      .rsp_frame_id    (rsp_frame_id),
      .rsp_length_code (rsp_length_code),
      .rsp_data_byte_0 (rsp_data_byte_0),
      .rsp_data_byte_1 (rsp_data_byte_1),
      .rsp_data_byte_2 (rsp_data_byte_2),
      .rsp_data_byte_3 (rsp_data_byte_3),
      .rsp_data_byte_4 (rsp_data_byte_4),
      .rsp_data_byte_5 (rsp_data_byte_5),
      .rsp_data_byte_6 (rsp_data_byte_6),
      .rsp_data_byte_7 (rsp_data_byte_7),
      .fail_count      (fail_count),
      .pending         (pending),
      .accepted_frames (accepted_frames),
      .rejected_lines  (rejected_lines)
   );

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d frames still pending", cycle_count, pending);
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // response side backpressure
   initial begin
      rsp_ready <= 1'b0;
      forever begin
         @(posedge clock);
         if (rsp_hold) rsp_ready <= 1'b0;
         else rsp_ready <= ($urandom_range(99) >= recv_idle);
      end
   end

   // one character transaction, valid held until accepted
   task automatic send_char(logic [7:0] c);
      while ($urandom_range(99) < send_idle) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid   <= 1'b1;
      req_char_in <= c;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
   endtask

   task automatic send_text(string s);
      for (int i = 0; i < s.len(); i++) send_char(s[i]);
   endtask

   task automatic send_line(string s, logic [7:0] term);
      send_text(s);
      send_char(term);
   endtask

   task automatic push_text(string s);
      for (int i = 0; i < s.len(); i++) line_q.push_back(s[i]);
   endtask

   function automatic logic [7:0] hex_digit_char(logic [3:0] v, bit upper);
      if (v < 4'd10) return 8'("0" + v);
      return upper ? 8'("A" + v - 4'd10) : 8'("a" + v - 4'd10);
   endfunction

   function automatic logic [7:0] pick_blank();
      case ($urandom_range(3))
         0: return CH_SPACE;
         1: return CH_TAB;
         2: return CH_VT;
         default: return CH_FF;
      endcase
   endfunction

   task automatic push_hex_digit();
      line_q.push_back(hex_digit_char(4'($urandom_range(15)), bit'($urandom_range(1))));
   endtask

   task automatic build_frame_line();
      int n;
      line_q.delete();
      push_text("CAN:");
      if ($urandom_range(3) == 0) repeat ($urandom_range(1, 3)) line_q.push_back(pick_blank());
      case ($urandom_range(3))
         0: line_q.push_back(CH_PLUS);
         1: line_q.push_back(CH_MINUS);
         default: begin
         end
      endcase
      if ($urandom_range(2) == 0) begin
         line_q.push_back(CH_ZERO);
         line_q.push_back($urandom_range(1) ? CH_UP_X : CH_LO_X);
      end
      n = ($urandom_range(4) == 0) ? $urandom_range(9, 12) : $urandom_range(1, 8);
      repeat (n) push_hex_digit();
      line_q.push_back(CH_COLON);
      line_q.push_back(8'(CH_ZERO + $urandom_range(8)));
      line_q.push_back(CH_COLON);
      n = ($urandom_range(5) == 0) ? $urandom_range(9, 11) : $urandom_range(0, 8);
      repeat (2 * n + (($urandom_range(4) == 0) ? 1 : 0)) push_hex_digit();
   endtask

   task automatic send_random_line();
      int kind;
      int n;
      kind = $urandom_range(99);
      line_q.delete();
      if (kind < 60) begin
         build_frame_line();
      end else if (kind < 75) begin
         build_frame_line();
         repeat ($urandom_range(1, 2))
            line_q[$urandom_range(line_q.size() - 1)] = 8'($urandom_range(255));
      end else if (kind < 80) begin
         build_frame_line();
         line_q.insert($urandom_range(line_q.size()), CH_NUL);
      end else if (kind < 88) begin
         repeat ($urandom_range(1, 20)) line_q.push_back(8'($urandom_range(255)));
      end else if (kind < 95) begin
         build_frame_line();
         n = $urandom_range(64, 90);
         while (line_q.size() < n) push_hex_digit();
      end
      foreach (line_q[i]) send_char(line_q[i]);
      send_char($urandom_range(1) ? CH_CR : CH_LF);
      chars_sent += line_q.size() + 1;
      if ($urandom_range(7) == 0) begin
         send_char(CH_LF);
         chars_sent++;
      end
      lines_sent++;
   endtask

   task automatic run_random_phase(int sender_idle, int receiver_idle);
      int start;
      send_idle = sender_idle;
      recv_idle = receiver_idle;
      start     = chars_sent;
      while (chars_sent - start < PHASE_CHARS) send_random_line();
   endtask

   task automatic run_directed();
      string long_s;
      send_line("CAN:7FF:8:0011223344556677", CH_LF);
      send_line("CAN:0:0:", CH_CR);
      send_text("CAN: ");
      send_char(CH_TAB);
      send_char(CH_VT);
      send_char(CH_FF);
      send_line("+0x1aB:3:FFee", CH_LF);
      send_line("CAN:-1:1:80", CH_LF);
      send_line("CAN:FFFFFFFF:8:FF", CH_CR);
      send_line("CAN:123456789:2:0102", CH_LF);
      send_line("CAN:-123456789:2:01", CH_LF);
      send_line("CAN:0x:1:00", CH_LF);
      send_line("CAN:0X", CH_LF);
      send_line("CAN:0:1:12", CH_LF);
      send_line("CAN:00012:8:A", CH_LF);
      send_line("CAN:1:8:12G", CH_LF);
      send_line("CAN:1:2:1G34", CH_LF);
      send_line("CAN:2:8:00112233445566778899AA", CH_LF);
      send_line("CAN:3:1:aabbcc", CH_LF);
      send_line("CAN:4:9:", CH_LF);
      send_line("CAN:5:4", CH_LF);
      send_line("CAN:5;4:", CH_LF);
      send_line("can:1:1:00", CH_LF);
      send_char(CH_LF);
      send_line("CAN:6:1:AB", CH_CR);
      send_char(CH_LF);
      send_text("CAN:6:1:AB");
      send_char(CH_NUL);
      send_line("ZZ", CH_LF);
      send_text("CAN");
      send_char(CH_NUL);
      send_line(":1:0:", CH_LF);
      send_char(8'hFF);
      send_char(CH_CR);
      long_s = "CAN:";
      repeat (70) long_s = {long_s, " "};
      send_line({long_s, "1:1:00"}, CH_LF);
      long_s = "CAN:";
      repeat (50) long_s = {long_s, "0"};
      send_line({long_s, "1:2:AB"}, CH_LF);
   endtask

   initial begin
      reset       <= 1'b1;
      req_valid   <= 1'b0;
      req_char_in <= 8'h00;
      rsp_hold    <= 1'b0;
      send_idle   = 0;
      recv_idle   = 0;
      chars_sent  = 0;
      lines_sent  = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      send_idle = 36;
      recv_idle = 58;
      run_directed();

      run_random_phase(36, 58);
      run_random_phase(58, 36);

      // response side stalled while the sender keeps pushing short frames
      send_idle = 0;
      fork
         begin
            rsp_hold <= 1'b1;
            repeat (400) @(posedge clock);
            rsp_hold <= 1'b0;
         end
         begin
            repeat (40) begin
               line_q.delete();
               push_text("CAN:");
               push_hex_digit();
               line_q.push_back(CH_COLON);
               line_q.push_back(8'(CH_ZERO + $urandom_range(8)));
               line_q.push_back(CH_COLON);
               foreach (line_q[i]) send_char(line_q[i]);
               send_char(CH_LF);
            end
         end
      join

      run_random_phase(0, 0);

      req_valid <= 1'b0;
      do @(posedge clock); while (pending != 0);
      repeat (20) @(posedge clock);

      $display("covered %0d random lines (%0d chars) under three idle mixes and a long stall",
               lines_sent, chars_sent);
      $display("frames accepted %0d, lines rejected %0d, mismatches %0d",
               accepted_frames, rejected_lines, fail_count);
      if (fail_count == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule

FILE: sim.f
hdl/ascf_pkg.sv
hdl/ascf_parser_core.sv
hdl/ascf_rsp_skid.sv
hdl/ascii_can_frame_line_parser.sv
verif/ascf_frame_checker.sv
verif/ascii_can_frame_line_parser_tb.sv
